@@ rtl/core/a52_pkg.sv @@
// Shared types, constants and LFSR helper functions for the A5/2 keystream core
`timescale 1ns / 1ps
`default_nettype none
package a52_pkg;

    // Operation codes carried by a request
    localparam logic OP_SETUP    = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // Register geometry
    localparam int unsigned R1_W = 19;
    localparam int unsigned R2_W = 22;
    localparam int unsigned R3_W = 23;
    localparam int unsigned R4_W = 17;

    localparam logic [R1_W-1:0] TAPS_ONE   = 19'h72000;
    localparam logic [R2_W-1:0] TAPS_TWO   = 22'h300000;
    localparam logic [R3_W-1:0] TAPS_THREE = 23'h700080;
    localparam logic [R4_W-1:0] TAPS_CTRL  = 17'h10800;

    // Load phase: key bits first, then frame bits
    localparam int unsigned KEY_BITS   = 64;
    localparam int unsigned FRAME_BITS = 22;
    localparam int unsigned LOAD_STEPS = KEY_BITS + FRAME_BITS;
    localparam int unsigned LOAD_IDX_W = $clog2(LOAD_STEPS);

    // APB register map
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 64;
    localparam logic        REG_CIPHER_KEY = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MIX,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  clear;
        logic                  force_step;
        logic                  last_load;
        logic [LOAD_IDX_W-1:0] bit_idx;
        logic                  maj_step;
        logic                  rsp_gen;
        logic                  rsp_setup;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic slot_free;
    } t_dp_sts;

    function automatic logic maj3(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

    function automatic logic [R1_W-1:0] step_one(input logic [R1_W-1:0] r, input logic frc);
        logic [R1_W-1:0] n;
        n = {r[R1_W-2:0], ^(r & TAPS_ONE)};
        n[15] = n[15] | frc;
        return n;
    endfunction

    function automatic logic [R2_W-1:0] step_two(input logic [R2_W-1:0] r, input logic frc);
        logic [R2_W-1:0] n;
        n = {r[R2_W-2:0], ^(r & TAPS_TWO)};
        n[16] = n[16] | frc;
        return n;
    endfunction

    function automatic logic [R3_W-1:0] step_three(input logic [R3_W-1:0] r,
                                                   input logic frc);
        logic [R3_W-1:0] n;
        n = {r[R3_W-2:0], ^(r & TAPS_THREE)};
        n[18] = n[18] | frc;
        return n;
    endfunction

    function automatic logic [R4_W-1:0] step_ctrl(input logic [R4_W-1:0] r, input logic frc);
        logic [R4_W-1:0] n;
        n = {r[R4_W-2:0], ^(r & TAPS_CTRL)};
        n[10] = n[10] | frc;
        return n;
    endfunction

    // Combine top bits with one majority function per register
    function automatic logic out_fn(input logic [R1_W-1:0] r1, input logic [R2_W-1:0] r2,
                                    input logic [R3_W-1:0] r3);
        return r1[18] ^ r2[21] ^ r3[22]
             ^ maj3(r1[15], ~r1[14], r1[12])
             ^ maj3(~r2[16], r2[13], r2[9])
             ^ maj3(r3[18], r3[16], ~r3[13]);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/a52_req_if.sv @@
// Request channel interface: operation and frame number
`timescale 1ns / 1ps
`default_nettype none
interface a52_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [21:0] frame_number;

    modport source (output valid, output operation, output frame_number, input ready);
    modport sink   (input valid, input operation, input frame_number, output ready);
endinterface
`default_nettype wire

@@ rtl/core/a52_rsp_if.sv @@
// Response channel interface: keystream bit and setup acknowledge
`timescale 1ns / 1ps
`default_nettype none
interface a52_rsp_if;
    logic valid;
    logic ready;
    logic keystream_bit;
    logic setup_done;

    modport source (output valid, output keystream_bit, output setup_done, input ready);
    modport sink   (input valid, input keystream_bit, input setup_done, output ready);
endinterface
`default_nettype wire

@@ rtl/core/a52_ctrl.sv @@
// Sequencing controller: request acceptance, load and mix step counting
`timescale 1ns / 1ps
`default_nettype none
module a52_ctrl #(
    parameter int unsigned MIX_CLOCKS = 100
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    a52_req_if.sink                i_req,
    input  wire a52_pkg::t_dp_sts  i_sts,
    output a52_pkg::t_dp_cmd       o_cmd
);

    localparam int unsigned SPAN  = (MIX_CLOCKS > a52_pkg::LOAD_STEPS) ?
                                    MIX_CLOCKS : a52_pkg::LOAD_STEPS;
    localparam int unsigned CNT_W = $clog2(SPAN);
    localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(a52_pkg::LOAD_STEPS - 1);
    localparam logic [CNT_W-1:0] MIX_LAST  = CNT_W'(MIX_CLOCKS - 1);

    a52_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= a52_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        i_req.ready = 1'b0;
        case (r_state)
            a52_pkg::ST_IDLE: begin
                i_req.ready = i_sts.slot_free;
                if (i_req.valid && i_sts.slot_free) begin
                    if (i_req.operation == a52_pkg::OP_GENERATE) begin
                        o_cmd.maj_step = 1'b1;
                        o_cmd.rsp_gen  = 1'b1;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_cnt       = '0;
                        n_state     = a52_pkg::ST_LOAD;
                    end
                end
            end
            a52_pkg::ST_LOAD: begin
                // Clock all registers and fold in one key or frame bit
                o_cmd.force_step = 1'b1;
                o_cmd.bit_idx    = r_cnt[a52_pkg::LOAD_IDX_W-1:0];
                o_cmd.last_load  = (r_cnt == LOAD_LAST);
                if (r_cnt == LOAD_LAST) begin
                    n_cnt   = '0;
                    n_state = a52_pkg::ST_MIX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            a52_pkg::ST_MIX: begin
                o_cmd.maj_step = 1'b1;
                if (r_cnt == MIX_LAST) begin
                    n_state = a52_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            a52_pkg::ST_DONE: begin
                // Hold until the response slot frees, then acknowledge setup
                if (i_sts.slot_free) begin
                    o_cmd.rsp_setup = 1'b1;
                    n_state         = a52_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = a52_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/a52_dp.sv @@
// Datapath: the four LFSRs, output delay bit and response register
`timescale 1ns / 1ps
`default_nettype none
module a52_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire a52_pkg::t_dp_cmd               i_cmd,
    input  wire [a52_pkg::KEY_BITS-1:0]         i_cipher_key,
    input  wire [a52_pkg::FRAME_BITS-1:0]       i_frame_number,
    output a52_pkg::t_dp_sts                    o_sts,
    a52_rsp_if.source                           o_rsp
);

    logic [a52_pkg::R1_W-1:0]       r_r1, n_r1;
    logic [a52_pkg::R2_W-1:0]       r_r2, n_r2;
    logic [a52_pkg::R3_W-1:0]       r_r3, n_r3;
    logic [a52_pkg::R4_W-1:0]       r_r4, n_r4;
    logic                           r_delay, n_delay;
    logic [a52_pkg::FRAME_BITS-1:0] r_frame;
    logic                           r_rsp_valid, n_rsp_valid;
    logic                           r_rsp_bit, r_rsp_done;

    logic maj, en1, en2, en3, in_bit, any_step;

    // Majority clock control from R4
    assign maj      = a52_pkg::maj3(r_r4[10], r_r4[3], r_r4[7]);
    assign en1      = i_cmd.force_step | (r_r4[10] == maj);
    assign en2      = i_cmd.force_step | (r_r4[3] == maj);
    assign en3      = i_cmd.force_step | (r_r4[7] == maj);
    assign any_step = i_cmd.force_step | i_cmd.maj_step;

    // Pick the key bit, then the frame bits once the key is in
    assign in_bit = i_cmd.bit_idx[a52_pkg::LOAD_IDX_W-1] ? r_frame[i_cmd.bit_idx[4:0]]
                                                         : i_cipher_key[i_cmd.bit_idx[5:0]];

    always_comb begin
        n_r1    = r_r1;
        n_r2    = r_r2;
        n_r3    = r_r3;
        n_r4    = r_r4;
        n_delay = r_delay;
        if (i_cmd.clear) begin
            n_r1 = '0;
            n_r2 = '0;
            n_r3 = '0;
            n_r4 = '0;
        end else if (any_step) begin
            if (en1) n_r1 = a52_pkg::step_one(r_r1, i_cmd.last_load);
            if (en2) n_r2 = a52_pkg::step_two(r_r2, i_cmd.last_load);
            if (en3) n_r3 = a52_pkg::step_three(r_r3, i_cmd.last_load);
            n_r4 = a52_pkg::step_ctrl(r_r4, i_cmd.last_load);
            if (i_cmd.force_step) begin
                n_r1[0] = n_r1[0] ^ in_bit;
                n_r2[0] = n_r2[0] ^ in_bit;
                n_r3[0] = n_r3[0] ^ in_bit;
                n_r4[0] = n_r4[0] ^ in_bit;
            end else begin
                // Refresh the delay bit from the stepped registers
                n_delay = a52_pkg::out_fn(n_r1, n_r2, n_r3);
            end
        end
    end

    // Response slot: load on a new result, drop once taken
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (i_cmd.rsp_gen || i_cmd.rsp_setup) begin
            n_rsp_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1        <= '0;
            r_r2        <= '0;
            r_r3        <= '0;
            r_r4        <= '0;
            r_delay     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_r1        <= n_r1;
            r_r2        <= n_r2;
            r_r3        <= n_r3;
            r_r4        <= n_r4;
            r_delay     <= n_delay;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_frame <= i_frame_number;
        end
        if (i_cmd.rsp_gen || i_cmd.rsp_setup) begin
            r_rsp_bit  <= i_cmd.rsp_gen & r_delay;
            r_rsp_done <= i_cmd.rsp_setup;
        end
    end

    assign o_sts.slot_free    = ~r_rsp_valid | o_rsp.ready;
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.keystream_bit = r_rsp_bit;
    assign o_rsp.setup_done   = r_rsp_done;

endmodule
`default_nettype wire

@@ rtl/core/a52_keystream_generator_core.sv @@
// Top level of the A5/2 keystream core: APB key register, controller and datapath
//
//   Channel   Dir  Handshake              Contents
//   i_req     in   valid/ready            operation, frame_number
//   o_rsp     out  valid/ready            keystream_bit, setup_done
//   APB       in   psel/penable/pwrite    cipher_key at byte address 0
//
// A generate request does one majority clock of the LFSRs, and the delayed
// bit goes to the response register; requests may follow every cycle while
// the response slot is free. A setup request clears the LFSRs, loads the key
// and frame bits, mixes, then acknowledges once the response slot is free.
// Reset is synchronous, active low, and zeroes the LFSRs, delay bit and key.
// A stalled response holds its register; a new request is taken when it leaves.
`timescale 1ns / 1ps
`default_nettype none
module a52_keystream_generator_core #(
    parameter int unsigned MIX_CLOCKS = 100
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    a52_req_if.sink                          i_req,
    a52_rsp_if.source                        o_rsp,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [a52_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire [a52_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [a52_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [a52_pkg::KEY_BITS-1:0] r_cipher_key;
    logic                         key_wr, key_sel;
    a52_pkg::t_dp_cmd             cmd;
    a52_pkg::t_dp_sts             sts;

    // Key register write on the APB access cycle
    assign key_sel = (paddr[a52_pkg::APB_ADDR_W-1] == a52_pkg::REG_CIPHER_KEY);
    assign key_wr  = psel & penable & pwrite & key_sel;
    assign pready  = 1'b1;
    assign prdata  = key_sel ? r_cipher_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
        end else if (key_wr) begin
            r_cipher_key <= pwdata;
        end
    end

    a52_ctrl #(
        .MIX_CLOCKS (MIX_CLOCKS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    a52_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cipher_key   (r_cipher_key),
        .i_frame_number (i_req.frame_number),
        .o_sts          (sts),
        .o_rsp          (o_rsp)
    );

`ifndef SYNTH
    // A setup request blocks further requests on the next cycle
    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.operation == a52_pkg::OP_SETUP)
        |=> !i_req.ready)
        else $error("request taken during setup");

    // A generate request yields a keystream response on the next cycle
    a_gen_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.operation == a52_pkg::OP_GENERATE)
        |=> (o_rsp.valid && !o_rsp.setup_done))
        else $error("generate request without response");

    // A request is only taken when the response slot can receive its result
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (!o_rsp.valid || o_rsp.ready))
        else $error("request taken with response slot full");
`endif

endmodule
`default_nettype wire

@@ bench/tb_a52_keystream_generator_core.sv @@
// Self-checking bench for the A5/2 keystream core: request/response traffic and APB key writes
`timescale 1ns / 1ps
module tb_a52_keystream_generator_core;

    localparam int unsigned MIX_CLOCKS   = 100;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned PHASE_ITEMS  = 70;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam logic [a52_pkg::APB_ADDR_W-1:0] KEY_ADDR =
        a52_pkg::APB_ADDR_W'(8 * a52_pkg::REG_CIPHER_KEY);

    typedef struct packed {
        logic        operation;
        logic [21:0] frame_number;
    } t_request;

    typedef struct packed {
        logic keystream_bit;
        logic setup_done;
    } t_keystream_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [a52_pkg::APB_ADDR_W-1:0] paddr;
    logic [a52_pkg::APB_DATA_W-1:0] pwdata;
    logic [a52_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    a52_req_if req_chan ();
    a52_rsp_if rsp_chan ();

    a52_keystream_generator_core #(
        .MIX_CLOCKS (MIX_CLOCKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_chan),
        .o_rsp   (rsp_chan),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    t_request          pending_requests[$];
    t_keystream_result expected_bits[$];
    int                fail_count     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                send_calm      = 0;
    int                recv_calm      = 0;

    // Shadow copy of the cipher state
    logic [63:0]   session_key = '0;
    logic [a52_pkg::R1_W-1:0] shadow_one   = '0;
    logic [a52_pkg::R2_W-1:0] shadow_two   = '0;
    logic [a52_pkg::R3_W-1:0] shadow_three = '0;
    logic [a52_pkg::R4_W-1:0] shadow_ctrl  = '0;
    logic                     shadow_delay = 1'b0;

    function automatic logic vote3(input logic a, input logic b, input logic c);
        return (a & b) | (a & c) | (b & c);
    endfunction

    // Clock the four registers once, forced or under majority control
    function automatic void clock_registers(input logic forced, input logic last_load);
        logic m;
        logic [a52_pkg::R4_W-1:0] c;
        c = shadow_ctrl;
        m = vote3(c[10], c[3], c[7]);
        if (forced || c[10] == m)
            shadow_one = {shadow_one[a52_pkg::R1_W-2:0], ^(shadow_one & a52_pkg::TAPS_ONE)}
                       | (a52_pkg::R1_W'(last_load) << 15);
        if (forced || c[3] == m)
            shadow_two = {shadow_two[a52_pkg::R2_W-2:0], ^(shadow_two & a52_pkg::TAPS_TWO)}
                       | (a52_pkg::R2_W'(last_load) << 16);
        if (forced || c[7] == m)
            shadow_three = {shadow_three[a52_pkg::R3_W-2:0],
                            ^(shadow_three & a52_pkg::TAPS_THREE)}
                         | (a52_pkg::R3_W'(last_load) << 18);
        shadow_ctrl = {c[a52_pkg::R4_W-2:0], ^(c & a52_pkg::TAPS_CTRL)}
                    | (a52_pkg::R4_W'(last_load) << 10);
    endfunction

    function automatic void inject_bit(input logic b);
        shadow_one[0]   = shadow_one[0] ^ b;
        shadow_two[0]   = shadow_two[0] ^ b;
        shadow_three[0] = shadow_three[0] ^ b;
        shadow_ctrl[0]  = shadow_ctrl[0] ^ b;
    endfunction

    // Refresh the delay bit and hand back its previous value
    function automatic logic shift_out_bit();
        logic prev;
        prev = shadow_delay;
        shadow_delay = shadow_one[18] ^ shadow_two[21] ^ shadow_three[22]
                     ^ vote3(shadow_one[15], ~shadow_one[14], shadow_one[12])
                     ^ vote3(~shadow_two[16], shadow_two[13], shadow_two[9])
                     ^ vote3(shadow_three[18], shadow_three[16], ~shadow_three[13]);
        return prev;
    endfunction

    // Work out the response to one accepted request and store it
    function automatic void advance_cipher(input logic operation, input logic [21:0] frame);
        t_keystream_result res;
        if (operation == a52_pkg::OP_SETUP) begin
            shadow_one   = '0;
            shadow_two   = '0;
            shadow_three = '0;
            shadow_ctrl  = '0;
            for (int i = 0; i < a52_pkg::KEY_BITS; i++) begin
                clock_registers(1'b1, 1'b0);
                inject_bit(session_key[i]);
            end
            for (int i = 0; i < a52_pkg::FRAME_BITS; i++) begin
                clock_registers(1'b1, i == a52_pkg::FRAME_BITS - 1);
                inject_bit(frame[i]);
            end
            for (int i = 0; i < MIX_CLOCKS; i++)
                clock_registers(1'b0, 1'b0);
            void'(shift_out_bit());
            res.keystream_bit = 1'b0;
            res.setup_done    = 1'b1;
        end else begin
            clock_registers(1'b0, 1'b0);
            res.keystream_bit = shift_out_bit();
            res.setup_done    = 1'b0;
        end
        expected_bits.insert(expected_bits.size(), res);
    endfunction

    // Request driver: hold the request until taken, then offer the next one
    always @(posedge i_clk) begin : request_driver
        logic go;
        if (!i_rst_n) begin
            req_chan.valid <= 1'b0;
        end else begin
            if (req_chan.valid && req_chan.ready) begin
                advance_cipher(req_chan.operation, req_chan.frame_number);
                void'(pending_requests.pop_front());
            end
            if (!req_chan.valid || req_chan.ready) begin
                if (send_calm != 0)
                    send_calm--;
                else if ($urandom_range(255) == 0)
                    send_calm = $urandom_range(64, 16);
                go = (send_calm != 0) || ($urandom_range(99) >= send_idle_pct);
                if (pending_requests.size() != 0 && go) begin
                    req_chan.valid        <= 1'b1;
                    req_chan.operation    <= pending_requests[0].operation;
                    req_chan.frame_number <= pending_requests[0].frame_number;
                end else begin
                    req_chan.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compare each response with the oldest expectation
    always @(posedge i_clk) begin : response_monitor
        t_keystream_result want;
        if (!i_rst_n) begin
            rsp_chan.ready <= 1'b0;
        end else begin
            if (rsp_chan.valid && rsp_chan.ready) begin
                if (expected_bits.size() == 0) begin
                    $error("unexpected response: keystream_bit %0b setup_done %0b",
                           rsp_chan.keystream_bit, rsp_chan.setup_done);
                    fail_count++;
                end else begin
                    want = expected_bits.pop_front();
                    if (rsp_chan.keystream_bit !== want.keystream_bit) begin
                        $error("keystream_bit: expected %0b, actual %0b",
                               want.keystream_bit, rsp_chan.keystream_bit);
                        fail_count++;
                    end
                    if (rsp_chan.setup_done !== want.setup_done) begin
                        $error("setup_done: expected %0b, actual %0b",
                               want.setup_done, rsp_chan.setup_done);
                        fail_count++;
                    end
                end
            end
            if (recv_calm != 0)
                recv_calm--;
            else if ($urandom_range(255) == 0)
                recv_calm = $urandom_range(64, 16);
            rsp_chan.ready <= (recv_calm != 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [21:0] random_frame();
        logic [31:0] r;
        r = $urandom();
        return r[21:0];
    endfunction

    task automatic queue_request(input logic operation, input logic [21:0] frame);
        t_request item;
        item.operation    = operation;
        item.frame_number = frame;
        pending_requests.insert(pending_requests.size(), item);
    endtask

    // Wait until every request is taken and every response has come
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_chan.valid || expected_bits.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the session key over APB and read it back
    task automatic write_cipher_key(input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        session_key = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            $error("cipher_key: expected %h, actual %h", value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Frames of setup plus a burst of keystream requests, with some noise
    task automatic queue_random_frames(input int count);
        int  queued;
        int  burst;
        bit  paused;
        queued = 0;
        paused = 0;
        while (queued < count) begin
            if ($urandom_range(99) < 8) begin
                queue_request(1'($urandom_range(1)), random_frame());
                queued++;
            end else begin
                queue_request(a52_pkg::OP_SETUP, random_frame());
                burst = ($urandom_range(9) == 0) ? 228 : $urandom_range(40, 1);
                repeat (burst) queue_request(a52_pkg::OP_GENERATE, random_frame());
                queued += burst + 1;
            end
            // Hold off the sender once until the block has answered everything
            if (!paused && queued >= count / 2) begin
                paused = 1;
                wait_drained();
            end
        end
    endtask

    initial begin : stimulus
        logic [63:0] key;
        req_chan.valid        = 1'b0;
        req_chan.operation    = a52_pkg::OP_GENERATE;
        req_chan.frame_number = '0;
        rsp_chan.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Keystream before any setup, then setups at the frame extremes, reset key
        queue_request(a52_pkg::OP_GENERATE, 22'h000000);
        queue_request(a52_pkg::OP_GENERATE, 22'h3FFFFF);
        queue_request(a52_pkg::OP_GENERATE, 22'h000000);
        queue_request(a52_pkg::OP_SETUP, 22'h000000);
        repeat (3) queue_request(a52_pkg::OP_GENERATE, 22'h3FFFFF);
        queue_request(a52_pkg::OP_SETUP, 22'h3FFFFF);
        repeat (3) queue_request(a52_pkg::OP_GENERATE, 22'h000000);
        wait_drained();

        // All-ones key, alternating frames and back-to-back setups
        write_cipher_key(64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(a52_pkg::OP_SETUP, 22'h2AAAAA);
        repeat (3) queue_request(a52_pkg::OP_GENERATE, 22'h155555);
        queue_request(a52_pkg::OP_SETUP, 22'h155555);
        repeat (2) queue_request(a52_pkg::OP_GENERATE, 22'h2AAAAA);
        queue_request(a52_pkg::OP_SETUP, 22'h000001);
        queue_request(a52_pkg::OP_SETUP, 22'h200000);
        repeat (2) queue_request(a52_pkg::OP_GENERATE, 22'h000000);
        wait_drained();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                1:       key = 64'h0;
                3:       key = 64'h8000_0000_0000_0001;
                4:       key = 64'hFFFF_FFFF_FFFF_FFFF;
                default: key = {$urandom(), $urandom()};
            endcase
            write_cipher_key(key);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            queue_random_frames(PHASE_ITEMS);
            wait_drained();
        end

        // Let any stray response show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bits.size() != 0) begin
            $error("%0d responses never arrived", expected_bits.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/a52_pkg.sv
rtl/core/a52_req_if.sv
rtl/core/a52_rsp_if.sv
rtl/core/a52_ctrl.sv
rtl/core/a52_dp.sv
rtl/core/a52_keystream_generator_core.sv
bench/tb_a52_keystream_generator_core.sv
